FILE: rtl/rate_limited_cost_grid_update_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cost grid update core
// Shared helpers that wrap concurrent assertions on a clock and a reset.
// ----------------------------------------------------------------------------
`ifndef RATE_LIMITED_COST_GRID_UPDATE_CORE_DEFINES_SVH
`define RATE_LIMITED_COST_GRID_UPDATE_CORE_DEFINES_SVH

// same-cycle implication
`define RLCG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlcg assertion failed");

// next-cycle implication
`define RLCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlcg assertion failed");

`endif

FILE: rtl/rlcg_pkg.sv
// ----------------------------------------------------------------------------
// rlcg_pkg
// Types, constants and helpers of the cost grid update core.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcg_pkg;

   localparam int GRID_CELLS = 65536;
   localparam int GRID_AW    = $clog2(GRID_CELLS);
   localparam int COST_W     = 8;

   localparam logic [COST_W-1:0] NO_INFO        = 8'd255;
   localparam logic [COST_W-1:0] INC_STEP_RESET = 8'd32;
   localparam logic [COST_W-1:0] DEC_STEP_RESET = 8'd8;
   localparam logic signed [7:0] OBS_UNKNOWN    = -8'sd1;
   localparam logic signed [7:0] OBS_MAX        = 8'sd100;
   localparam logic [15:0]       FULL_SCALE     = 16'd254;
   localparam logic [15:0]       PERCENT        = 16'd100;
   // 254/100 as a rounded-up fixed-point factor; exact floor for 0..100
   localparam int                SCALE_SHIFT    = 10;
   localparam int                SCALE_RECIP    =
      (int'(FULL_SCALE) * (1 << SCALE_SHIFT) + int'(PERCENT) - 1) / int'(PERCENT);

   typedef enum logic [0:0] {
      KIND_OBSERVE = 1'b0,
      KIND_MERGE   = 1'b1
   } kind_type;

   typedef enum logic [0:0] {
      CSR_INC_STEP = 1'b0,
      CSR_DEC_STEP = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [7:0]  observation;
      logic [COST_W-1:0]  master_cost;
   } op_type;

   typedef struct packed {
      logic               wr_en;
      logic [COST_W-1:0]  cell_cost;
      logic [COST_W-1:0]  merged_cost;
      logic               master_written;
   } upd_type;

   // occupancy percent (0..100) to cost (0..254)
   function automatic logic [COST_W-1:0] scale_target(input logic [6:0] pct);
      logic [17:0] prod;
      begin
         prod = 18'(pct) * 18'(SCALE_RECIP);
         scale_target = prod[SCALE_SHIFT +: COST_W];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rate_limited_cost_grid_update_core.sv
// ----------------------------------------------------------------------------
// rate_limited_cost_grid_update_core
// Grid of 8-bit cell costs with rate-limited observe updates and master merge.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. Observe
//   items (req_kind 0) step one cell toward the cost of req_observation;
//   merge items (req_kind 1) compare req_master_cost with the cell cost.
//   Exactly one result per item: rsp_valid is high for one cycle with
//   rsp_cell_cost, rsp_merged_cost and rsp_master_written. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Sequence: the cell is read from the grid RAM at the accept edge, updated
//   and, for observe items, written back at the next edge, and the result
//   shows in the cycle after that. busy is high for one cycle after each
//   accept, so a new item can be taken only once the last result shows,
//   set by the single RAM read-modify-write per item.
//   Reset: the step registers return to 32 and 8 and the grid RAM is swept
//   to zero, one cell a cycle over all 65536 cells, with busy high.
//   csr_write_en writes the rise limit (index 0) or the fall limit (index 1)
//   at any edge; write them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rate_limited_cost_grid_update_core_defines.svh"

module rate_limited_cost_grid_update_core
   import rlcg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_kind,
   input  wire logic [15:0]         req_cell_index,
   input  wire logic signed [7:0]   req_observation,
   input  wire logic [7:0]          req_master_cost,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_cell_cost,
   output logic [7:0]               rsp_merged_cost,
   output logic                     rsp_master_written,
   input  wire logic                csr_write_en,
   input  wire logic [0:0]          csr_index,
   input  wire logic [7:0]          csr_wdata
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type          state_ff;
   logic [GRID_AW-1:0] clr_addr_ff;
   logic [GRID_AW-1:0] addr_ff;
   op_type             op_ff;
   logic               rsp_valid_ff;
   logic [COST_W-1:0]  rsp_cell_cost_ff;
   logic [COST_W-1:0]  rsp_merged_cost_ff;
   logic               rsp_master_written_ff;
   logic [COST_W-1:0]  rise_limit_ff;
   logic [COST_W-1:0]  fall_limit_ff;

   logic               accept;
   logic               ram_wr_en;
   logic [GRID_AW-1:0] ram_wr_addr;
   logic [COST_W-1:0]  ram_wr_data;
   logic [COST_W-1:0]  ram_rd_data;
   upd_type            upd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
         end
         ST_CALC: begin
            ram_wr_en   = upd.wr_en;
            ram_wr_addr = addr_ff;
            ram_wr_data = upd.cell_cost;
         end
         default: begin
            ram_wr_en   = 1'b0;
            ram_wr_addr = addr_ff;
            ram_wr_data = upd.cell_cost;
         end
      endcase
   end

   rlcg_ram #(
      .DEPTH (GRID_CELLS),
      .WIDTH (COST_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_cell_index[GRID_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   rlcg_update u_update (
      .op         (op_ff),
      .cur_cost   (ram_rd_data),
      .rise_limit (rise_limit_ff),
      .fall_limit (fall_limit_ff),
      .upd        (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + GRID_AW'(1);
               if (clr_addr_ff == GRID_AW'(GRID_CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  addr_ff <= req_cell_index[GRID_AW-1:0];
                  op_ff   <= '{kind:        kind_type'(req_kind),
                               observation: req_observation,
                               master_cost: req_master_cost};
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               rsp_valid_ff          <= 1'b1;
               rsp_cell_cost_ff      <= upd.cell_cost;
               rsp_merged_cost_ff    <= upd.merged_cost;
               rsp_master_written_ff <= upd.master_written;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_limit_ff <= INC_STEP_RESET;
         fall_limit_ff <= DEC_STEP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_INC_STEP: rise_limit_ff <= csr_wdata;
            CSR_DEC_STEP: fall_limit_ff <= csr_wdata;
            default:      rise_limit_ff <= rise_limit_ff;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_cost      = rsp_cell_cost_ff;
   assign rsp_merged_cost    = rsp_merged_cost_ff;
   assign rsp_master_written = rsp_master_written_ff;

   `RLCG_ASSERT_NEXT(a_accept_to_calc, clock, reset, accept, state_ff == ST_CALC)
   `RLCG_ASSERT_NEXT(a_calc_gives_result, clock, reset, state_ff == ST_CALC, rsp_valid_ff)
   `RLCG_ASSERT_NOW(a_result_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `RLCG_ASSERT_NOW(a_no_result_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   `RLCG_ASSERT_NOW(a_observe_never_no_info, clock, reset,
      rsp_valid_ff && op_ff.kind == KIND_OBSERVE, rsp_cell_cost_ff != NO_INFO)

endmodule

`default_nettype wire

FILE: rtl/rlcg_ram.sv
// ----------------------------------------------------------------------------
// rlcg_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcg_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rlcg_update.sv
// ----------------------------------------------------------------------------
// rlcg_update
// Cell cost update for observe items and master merge for merge items.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcg_update
   import rlcg_pkg::*;
(
   input  wire op_type              op,
   input  wire logic [COST_W-1:0]   cur_cost,
   input  wire logic [COST_W-1:0]   rise_limit,
   input  wire logic [COST_W-1:0]   fall_limit,
   output upd_type                  upd
);

   logic [6:0]        obs_sat;
   logic [COST_W-1:0] target;
   logic [COST_W-1:0] gap;
   logic [COST_W-1:0] obs_next;
   logic              take_layer;

   always_comb begin
      if (op.observation < 8'sd0) begin
         obs_sat = 7'd0;
      end else if (op.observation > OBS_MAX) begin
         obs_sat = OBS_MAX[6:0];
      end else begin
         obs_sat = op.observation[6:0];
      end
      target = scale_target(obs_sat);
      gap    = '0;

      if (op.observation == OBS_UNKNOWN) begin
         obs_next = (cur_cost != '0 && cur_cost != NO_INFO) ? cur_cost - 8'd1 : cur_cost;
      end else if (target > cur_cost) begin
         gap      = target - cur_cost;
         obs_next = (gap > rise_limit) ? cur_cost + rise_limit : target;
      end else if (target < cur_cost) begin
         gap      = cur_cost - target;
         obs_next = (gap > fall_limit) ? cur_cost - fall_limit : '0;
      end else begin
         obs_next = cur_cost;
      end

      take_layer = (cur_cost != NO_INFO) &&
                   (op.master_cost == NO_INFO || op.master_cost < cur_cost);

      case (op.kind)
         KIND_OBSERVE: begin
            upd.wr_en          = 1'b1;
            upd.cell_cost      = obs_next;
            upd.merged_cost    = '0;
            upd.master_written = 1'b0;
         end
         KIND_MERGE: begin
            upd.wr_en          = 1'b0;
            upd.cell_cost      = cur_cost;
            upd.merged_cost    = take_layer ? cur_cost : op.master_cost;
            upd.master_written = take_layer;
         end
         default: begin
            upd.wr_en          = 1'b0;
            upd.cell_cost      = cur_cost;
            upd.merged_cost    = op.master_cost;
            upd.master_written = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire
